// ----- rtl/lhr_pkg.sv -----
package lhr_pkg;

  // number formats
  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int TF        = 30;
  localparam int TURN_SH   = 32;

  localparam logic signed [63:0] ONE        = 64'sd1 <<< TF;
  localparam logic signed [63:0] LIM        = 64'sd1 <<< 61;
  localparam logic signed [63:0] TWO_PI_Q30 = 64'sd6746518852;
  localparam logic signed [33:0] CORDIC_K   = 34'sd652032874;
  localparam logic signed [63:0] EPS_RAW    =
    ((64'sd1 <<< (2 * FRAC_BITS)) + 64'sd500000) / 64'sd1000000;
  localparam logic signed [63:0] EPS        = (EPS_RAW < 64'sd1) ? 64'sd1 : EPS_RAW;
  localparam logic [31:0]        PERIOD_RESET = 32'd1 << FRAC_BITS;
  localparam logic signed [63:0] SAT_HI     = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO     = -SAT_HI - 64'sd1;
  localparam logic [4:0]         CORDIC_LAST = 5'd30;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_START_TIME   = 3'd0,
    REG_PERIOD       = 3'd1,
    REG_AMPLITUDE    = 3'd2,
    REG_CENTER_X     = 3'd3,
    REG_CENTER_Y     = 3'd4,
    REG_HOLD_HEADING = 3'd5,
    REG_HEADING_GAIN = 3'd6
  } cfg_reg_t;

  typedef enum logic {OP_MUL, OP_DIV} arith_op_t;

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} arith_state_t;

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_CORDIC, S_FIN} seq_state_t;

  // microcode steps, in order of issue
  typedef enum logic [5:0] {
    ST_DT_MOD, ST_TURN, ST_PHASE, ST_B30, ST_S2, ST_C2, ST_DEN2, ST_DEN3,
    ST_PX_DIV, ST_PX_MUL, ST_CS, ST_PY_DIV, ST_PY_MUL,
    ST_VX_NUM, ST_VX_DIV, ST_VX_AMP, ST_VX_B,
    ST_VY_DIV, ST_VY_AMP, ST_VY_B,
    ST_C4, ST_Q2, ST_Q3, ST_AX_NUM, ST_AX_DIV, ST_AX_AMP, ST_AX_B1, ST_AX_B2,
    ST_AY_NUM, ST_AY_DIV, ST_AY_AMP, ST_AY_B1, ST_AY_B2,
    ST_VX2, ST_VY2, ST_COS2, ST_VXAY, ST_VYAX, ST_RNUM, ST_RATE, ST_ACCUM
  } step_t;

  typedef struct packed {
    logic              start;
    arith_op_t         op;
    logic [5:0]        sh;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } arith_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
    logic [63:0]        rem;
  } arith_resp_t;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] clampl(input logic signed [63:0] v);
    if (v > LIM) return LIM;
    if (v < -LIM) return -LIM;
    return v;
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    return clampl(clampl(a) + clampl(b));
  endfunction

  function automatic logic signed [31:0] satw(input logic signed [63:0] v);
    if (v > SAT_HI) return 32'(SAT_HI);
    if (v < SAT_LO) return 32'(SAT_LO);
    return 32'(v);
  endfunction

  // arctangent of 2^-i in Q30
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  return 34'sd843314857;
      5'd1:  return 34'sd497837829;
      5'd2:  return 34'sd263043837;
      5'd3:  return 34'sd133525159;
      5'd4:  return 34'sd67021687;
      5'd5:  return 34'sd33543516;
      5'd6:  return 34'sd16775851;
      5'd7:  return 34'sd8388437;
      5'd8:  return 34'sd4194283;
      5'd9:  return 34'sd2097149;
      5'd10: return 34'sd1048576;
      5'd11: return 34'sd524288;
      5'd12: return 34'sd262144;
      5'd13: return 34'sd131072;
      5'd14: return 34'sd65536;
      5'd15: return 34'sd32768;
      5'd16: return 34'sd16384;
      5'd17: return 34'sd8192;
      5'd18: return 34'sd4096;
      5'd19: return 34'sd2048;
      5'd20: return 34'sd1024;
      5'd21: return 34'sd512;
      5'd22: return 34'sd256;
      5'd23: return 34'sd128;
      5'd24: return 34'sd64;
      5'd25: return 34'sd32;
      5'd26: return 34'sd16;
      5'd27: return 34'sd8;
      5'd28: return 34'sd4;
      5'd29: return 34'sd2;
      5'd30: return 34'sd1;
      default: return 34'sd0;
    endcase
  endfunction

endpackage

// ----- rtl/lhr_arith.sv -----
module lhr_arith (
  input  logic                clk,
  input  logic                rst,
  input  lhr_pkg::arith_req_t  req,
  output lhr_pkg::arith_resp_t resp
);
  import lhr_pkg::*;

  arith_state_t state, state_next;
  arith_op_t    op;
  logic [63:0]  ua, ub;
  logic         neg;
  logic [5:0]   sh;
  logic [6:0]   cnt;
  logic [127:0] acc;
  logic [63:0]  pp;
  logic [1:0]   pp_pos;
  logic [127:0] dvd;
  logic [63:0]  rem;
  logic [63:0]  quo;
  logic         over;

  logic [31:0]  ah, bh;
  logic [64:0]  rem_s;
  logic         ge;
  logic [127:0] prod_sh;
  logic [63:0]  mul_mag, div_mag, res_mag;

  // partial product selection and one restoring divide step
  always_comb begin
    ah    = cnt[0] ? ua[63:32] : ua[31:0];
    bh    = cnt[1] ? ub[63:32] : ub[31:0];
    rem_s = {rem, dvd[127]};
    ge    = rem_s >= {1'b0, ub};
  end

  // result scaling, saturation and sign
  always_comb begin
    prod_sh = acc >> sh;
    mul_mag = (|prod_sh[127:64]) ? 64'(LIM) : prod_sh[63:0];
    if (ub == 64'd0) begin
      div_mag = (ua == 64'd0) ? 64'd0 : 64'(LIM);
    end else begin
      div_mag = over ? 64'(LIM) : quo;
    end
    res_mag = (op == OP_MUL) ? mul_mag : div_mag;
    if (res_mag > 64'(LIM)) res_mag = 64'(LIM);
    resp.done = (state == A_FIN);
    resp.res  = neg ? -$signed(res_mag) : $signed(res_mag);
    resp.rem  = rem;
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      A_IDLE: if (req.start) state_next = (req.op == OP_MUL) ? A_MUL : A_DIV;
      A_MUL:  if (cnt[2:0] == 3'd4) state_next = A_FIN;
      A_DIV:  if (cnt == 7'd0) state_next = A_FIN;
      A_FIN:  state_next = A_IDLE;
      default: state_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= A_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      A_IDLE: begin
        if (req.start) begin
          op   <= req.op;
          ua   <= mag(req.a);
          ub   <= mag(req.b);
          neg  <= req.a[63] ^ req.b[63];
          sh   <= req.sh;
          acc  <= '0;
          dvd  <= {64'd0, mag(req.a)} << req.sh;
          rem  <= '0;
          quo  <= '0;
          over <= 1'b0;
          cnt  <= (req.op == OP_MUL) ? 7'd0 : 7'd127;
        end
      end
      A_MUL: begin
        if (cnt[2:0] != 3'd4) begin
          pp     <= ah * bh;
          pp_pos <= {1'b0, cnt[0]} + {1'b0, cnt[1]};
        end
        if (cnt[2:0] != 3'd0) acc <= acc + ({64'd0, pp} << (7'd32 * pp_pos));
        cnt <= cnt + 7'd1;
      end
      A_DIV: begin
        rem  <= ge ? 64'(rem_s - {1'b0, ub}) : rem_s[63:0];
        over <= over | quo[63];
        quo  <= {quo[62:0], ge};
        dvd  <= dvd << 1;
        cnt  <= cnt - 7'd1;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/lemniscate_heading_reference_top.sv -----
// Figure-eight reference generator: each sample_time transaction yields one result
// transaction with position, velocity, heading rate and the accumulated heading, all
// signed Q16.16 and saturated. Eleven divides (nine with hold_heading set) on the shared
// one-bit-per-cycle divider dominate the work, plus up to thirty multiplies on the shared
// 32x32 unit and 31 CORDIC rotations. in_ready is high only between items; a finished
// result waits in the output register while the next sample is taken. Configuration
// writes are always taken and belong in idle periods.
module lemniscate_heading_reference_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        sample_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] heading,
  output logic signed [31:0] heading_rate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import lhr_pkg::*;

  localparam logic signed [32:0] QTR_TURN  = 33'sd1 <<< 30;
  localparam logic signed [32:0] HALF_TURN = 33'sd1 <<< 31;

  // configuration registers
  logic [31:0]        start_time, period, heading_gain;
  logic signed [31:0] amplitude, center_x, center_y;
  logic               hold_heading;

  // sequencer and working registers
  seq_state_t         state, state_next;
  step_t              step;
  logic [4:0]         cord_i;
  logic signed [33:0] dt;
  logic [31:0]        per, r;
  logic signed [32:0] ang;
  logic               flip;
  logic signed [33:0] x, y, z, c, s;
  logic signed [63:0] b30, s2, c2, den2, den3, cs, t1, t2, vx2, vy2, cos2;
  logic signed [31:0] px, py, vx, vy, ax, ay, rate, heading_accum;

  arith_req_t  req;
  arith_resp_t resp;

  logic signed [63:0] den, qv, vsum, num, vx2e;
  logic signed [32:0] turn_s, ang_fold;
  logic               flip_w;
  logic signed [33:0] xs, ys, at, nx, ny, nz;
  logic               in_acc, out_free;

  lhr_arith u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .resp (resp)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign out_free  = !out_valid || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time   <= '0;
      period       <= PERIOD_RESET;
      amplitude    <= '0;
      center_x     <= '0;
      center_y     <= '0;
      hold_heading <= 1'b0;
      heading_gain <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_TIME:   start_time   <= cfg_data;
        REG_PERIOD:       period       <= cfg_data;
        REG_AMPLITUDE:    amplitude    <= $signed(cfg_data);
        REG_CENTER_X:     center_x     <= $signed(cfg_data);
        REG_CENTER_Y:     center_y     <= $signed(cfg_data);
        REG_HOLD_HEADING: hold_heading <= cfg_data[0];
        REG_HEADING_GAIN: heading_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared terms built from working registers
  always_comb begin
    den  = ONE + s2;
    qv   = c2 - 64'sd2 * ONE;
    vsum = sadd(vx2, vy2);
    num  = sadd(t1, -t2);
    vx2e = sadd(vx2, EPS);
  end

  // half-turn fold of the phase
  always_comb begin
    turn_s   = 33'($signed(resp.res[31:0]));
    ang_fold = turn_s;
    flip_w   = 1'b0;
    if (turn_s > QTR_TURN) begin
      ang_fold = turn_s - HALF_TURN;
      flip_w   = 1'b1;
    end else if (turn_s < -QTR_TURN) begin
      ang_fold = turn_s + HALF_TURN;
      flip_w   = 1'b1;
    end
  end

  // one cordic rotation
  always_comb begin
    xs = x >>> cord_i;
    ys = y >>> cord_i;
    at = atan_q30(cord_i);
    if (z >= 0) begin
      nx = x - ys;
      ny = y + xs;
      nz = z - at;
    end else begin
      nx = x + ys;
      ny = y - xs;
      nz = z + at;
    end
  end

  // microcode: operands of each step
  always_comb begin
    req.start = (state == S_ISSUE);
    req.op    = OP_MUL;
    req.sh    = 6'(TF);
    req.a     = '0;
    req.b     = '0;
    unique case (step)
      ST_DT_MOD: begin
        req.op = OP_DIV; req.sh = 6'd0;
        req.a = 64'(dt); req.b = $signed({32'd0, per});
      end
      ST_TURN: begin
        req.op = OP_DIV; req.sh = 6'(TURN_SH);
        req.a = $signed({32'd0, r}); req.b = $signed({32'd0, per});
      end
      ST_PHASE: begin
        req.sh = 6'(TURN_SH); req.a = 64'(ang); req.b = TWO_PI_Q30;
      end
      ST_B30: begin
        req.op = OP_DIV; req.sh = 6'(FRAC_BITS);
        req.a = TWO_PI_Q30; req.b = $signed({32'd0, per});
      end
      ST_S2:     begin req.a = 64'(s); req.b = 64'(s); end
      ST_C2:     begin req.a = 64'(c); req.b = 64'(c); end
      ST_DEN2:   begin req.a = den; req.b = den; end
      ST_DEN3:   begin req.a = den2; req.b = den; end
      ST_PX_DIV: begin req.op = OP_DIV; req.a = 64'(c); req.b = den; end
      ST_PX_MUL: begin req.a = 64'(amplitude); req.b = t1; end
      ST_CS:     begin req.a = 64'(c); req.b = 64'(s); end
      ST_PY_DIV: begin req.op = OP_DIV; req.a = cs; req.b = den; end
      ST_PY_MUL: begin req.a = 64'(amplitude); req.b = t1; end
      ST_VX_NUM: begin req.a = 64'(s); req.b = s2 - 64'sd3 * ONE; end
      ST_VX_DIV: begin req.op = OP_DIV; req.a = t1; req.b = den2; end
      ST_VX_AMP: begin req.a = 64'(amplitude); req.b = t1; end
      ST_VX_B:   begin req.a = t1; req.b = b30; end
      ST_VY_DIV: begin req.op = OP_DIV; req.a = ONE - 64'sd3 * s2; req.b = den2; end
      ST_VY_AMP: begin req.a = 64'(amplitude); req.b = t1; end
      ST_VY_B:   begin req.a = t1; req.b = b30; end
      ST_C4:     begin req.a = c2; req.b = c2; end
      ST_Q2:     begin req.a = qv; req.b = qv; end
      ST_Q3:     begin req.a = t2; req.b = qv; end
      ST_AX_NUM: begin req.a = 64'(c); req.b = t1 + 64'sd10 * c2 - 64'sd8 * ONE; end
      ST_AX_DIV: begin req.op = OP_DIV; req.a = t1; req.b = t2; end
      ST_AX_AMP: begin req.a = 64'(amplitude); req.b = t1; end
      ST_AX_B1:  begin req.a = t1; req.b = b30; end
      ST_AX_B2:  begin req.a = t1; req.b = b30; end
      ST_AY_NUM: begin req.a = cs; req.b = 64'sd3 * c2 + 64'sd2 * ONE; end
      ST_AY_DIV: begin req.op = OP_DIV; req.a = t1; req.b = den3; end
      ST_AY_AMP: begin req.a = 64'(amplitude); req.b = t1; end
      ST_AY_B1:  begin req.a = t1; req.b = b30; end
      ST_AY_B2:  begin req.a = t1; req.b = b30; end
      ST_VX2:    begin req.sh = 6'd0; req.a = 64'(vx); req.b = 64'(vx); end
      ST_VY2:    begin req.sh = 6'd0; req.a = 64'(vy); req.b = 64'(vy); end
      ST_COS2:   begin req.op = OP_DIV; req.a = vx2; req.b = vsum; end
      ST_VXAY:   begin req.sh = 6'd0; req.a = 64'(vx); req.b = 64'(ay); end
      ST_VYAX:   begin req.sh = 6'd0; req.a = 64'(vy); req.b = 64'(ax); end
      ST_RNUM:   begin req.a = num; req.b = cos2; end
      ST_RATE: begin
        req.op = OP_DIV; req.sh = 6'(FRAC_BITS); req.a = t1; req.b = vx2e;
      end
      ST_ACCUM: begin
        req.sh = 6'(FRAC_BITS);
        req.a = $signed({32'd0, heading_gain}); req.b = 64'(rate);
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_ISSUE;
      S_ISSUE: state_next = S_WAIT;
      S_WAIT: begin
        if (resp.done) begin
          if (step == ST_PHASE) state_next = S_CORDIC;
          else if ((step == ST_AY_B2 && hold_heading) || step == ST_ACCUM)
            state_next = S_FIN;
          else state_next = S_ISSUE;
        end
      end
      S_CORDIC: if (cord_i == CORDIC_LAST) state_next = S_ISSUE;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // accumulator and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      heading_accum <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (state == S_WAIT && resp.done && step == ST_ACCUM)
        heading_accum <= satw(sadd(64'(heading_accum), resp.res));
      if (state == S_FIN && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // working registers and write-back
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          step <= ST_DT_MOD;
          per  <= (period == 32'd0) ? 32'd1 : period;
          dt   <= $signed({2'b00, sample_time}) - $signed({2'b00, start_time});
        end
      end
      S_WAIT: begin
        if (resp.done) begin
          if (step != ST_PHASE) step <= step_t'(6'(step) + 6'd1);
          unique case (step)
            ST_DT_MOD: r <= (dt < 0 && resp.rem != 64'd0) ?
                            (per - resp.rem[31:0]) : resp.rem[31:0];
            ST_TURN: begin
              ang  <= ang_fold;
              flip <= flip_w;
            end
            ST_PHASE: begin
              z      <= 34'(resp.res);
              x      <= CORDIC_K;
              y      <= '0;
              cord_i <= '0;
            end
            ST_B30:    b30  <= resp.res;
            ST_S2:     s2   <= resp.res;
            ST_C2:     c2   <= resp.res;
            ST_DEN2:   den2 <= resp.res;
            ST_DEN3:   den3 <= resp.res;
            ST_PX_MUL: px   <= satw(sadd(64'(center_x), resp.res));
            ST_CS:     cs   <= resp.res;
            ST_PY_MUL: py   <= satw(sadd(64'(center_y), resp.res));
            ST_VX_B:   vx   <= satw(resp.res);
            ST_VY_B:   vy   <= satw(resp.res);
            ST_Q2:     t2   <= resp.res;
            ST_Q3:     t2   <= resp.res;
            ST_AX_B2:  ax   <= satw(resp.res);
            ST_AY_DIV: t1   <= -64'sd2 * resp.res;
            ST_AY_B2: begin
              ay <= satw(resp.res);
              if (hold_heading) rate <= '0;
            end
            ST_VX2:    vx2  <= resp.res;
            ST_VY2:    vy2  <= resp.res;
            ST_COS2:   cos2 <= (vsum == 64'sd0) ? ONE : resp.res;
            ST_VYAX:   t2   <= resp.res;
            ST_RATE:   rate <= satw(resp.res);
            ST_ACCUM:  ;
            default:   t1   <= resp.res;
          endcase
        end
      end
      S_CORDIC: begin
        x      <= nx;
        y      <= ny;
        z      <= nz;
        cord_i <= cord_i + 5'd1;
        if (cord_i == CORDIC_LAST) begin
          c    <= flip ? -nx : nx;
          s    <= flip ? -ny : ny;
          step <= ST_B30;
        end
      end
      S_FIN: begin
        if (out_free) begin
          pos_x        <= px;
          pos_y        <= py;
          vel_x        <= vx;
          vel_y        <= vy;
          heading      <= heading_accum;
          heading_rate <= rate;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/lhr_checker.sv -----
module lhr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [31:0]        sample_time,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] pos_x,
  input logic signed [31:0] pos_y,
  input logic signed [31:0] vel_x,
  input logic signed [31:0] vel_y,
  input logic signed [31:0] heading,
  input logic signed [31:0] heading_rate,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [31:0]        cfg_data
);

  // a held result keeps its heading and pos_x
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(heading) && $stable(pos_x))
    else $error("result changed while stalled");

  // the block is busy right after taking a sample
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice without computing");

  // a new result only appears after the block worked on an item
  a_rose: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work");

  // reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lemniscate_heading_reference_top lhr_checker u_lhr_checker (.*);
